// ===== rtl/core/gbp_pkg.sv =====
// Shared types and constants for the gshare predictor core.
`timescale 1ns / 1ps
package gbp_pkg;

    localparam int INDEX_BITS = 12;
    localparam int HIST_MAX   = 12;
    localparam int HIST_LIM   = (INDEX_BITS < HIST_MAX) ? INDEX_BITS : HIST_MAX;
    localparam int HM_W       = (INDEX_BITS > HIST_MAX) ? INDEX_BITS : HIST_MAX;
    localparam int ADDR_W     = 24;
    localparam int CFG_W      = 4;
    localparam int CTR_W      = 3;
    localparam int TOTAL_W    = 32;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 72;
    localparam int Q_DEPTH    = 4;   // power of two, pointers wrap
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [CFG_W-1:0] HIST_BITS_RESET = CFG_W'(8);
    localparam logic [CFG_W-1:0] HIST_LIM_CFG    = CFG_W'(HIST_LIM);
    localparam logic [CTR_W-1:0] CTR_INIT        = CTR_W'(4);
    localparam logic [CTR_W-1:0] CTR_MAX         = CTR_W'(7);
    localparam logic [CTR_W-1:0] CTR_MIN         = CTR_W'(0);

    typedef struct packed {
        logic [INDEX_BITS-1:0] idx;
        logic                  taken;
    } q_entry_t;

    typedef struct packed {
        logic               head_valid;
        logic               full;
        logic [Q_CNT_W-1:0] count;
    } q_status_t;

    typedef struct packed {
        logic clr_done;
        logic busy;
    } back_status_t;

endpackage

// ===== rtl/core/gshare_branch_predictor_core.sv =====
// Path: queue, b stage, output register; one word per cycle while m_tready is high.
// The counter table sees one read and one write per cycle; a hit on the entry the
// previous word just updated is forwarded, so back-to-back words on one entry keep pace.
// Reset (aresetn low, synchronous) clears history, totals and queue, then the table's
// 4096 entries are filled with weakly-taken counters, during which s_tready stays low.
`timescale 1ns / 1ps
module gshare_branch_predictor_core import gbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,   // history_bits
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,    // [23:0] branch_address, [24] resolved_taken
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata     // [0] predicted_taken, [1] mispredicted,
                                             // [33:2] prediction_total,
                                             // [65:34] misprediction_total
);

    logic         push;
    q_entry_t     push_entry;
    logic         pop;
    q_entry_t     head;
    q_status_t    q_status;
    back_status_t back_status;

    gbp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_status    (q_status),
        .back_status (back_status),
        .push        (push),
        .push_entry  (push_entry)
    );

    gbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    gbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .status   (back_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !back_status.clr_done |-> !s_tready)
        else $error("input accepted while table clear runs");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(back_status.clr_done) |-> (!q_status.head_valid && !back_status.busy))
        else $error("work pending when table clear finished");

    a_pop_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_status.head_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/gbp_front.sv =====
// Front end: takes branch words, forms the table index and updates global history.
`timescale 1ns / 1ps
module gbp_front import gbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  q_status_t            q_status,
    input  back_status_t         back_status,
    output logic                 push,
    output q_entry_t             push_entry
);

    logic [CFG_W-1:0]      hist_bits_reg;
    logic [HIST_MAX-1:0]   hist_reg;
    logic [HIST_MAX-1:0]   hist_next;
    logic [CFG_W-1:0]      n_eff;
    logic [HIST_MAX:0]     hmask_wide;
    logic [HIST_MAX-1:0]   hmask;
    logic [HIST_MAX-1:0]   hist_used;
    logic [HIST_MAX-1:0]   taken_bit;
    logic [HM_W-1:0]       hist_ext;
    logic [ADDR_W-1:0]     addr;
    logic [INDEX_BITS-1:0] word_lo;

    assign cfg_ready = 1'b1;
    assign s_tready  = back_status.clr_done && !q_status.full;
    assign push      = s_tvalid && s_tready;

    // Clamp history length to 1 .. HIST_LIM.
    always_comb begin
        if (hist_bits_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (hist_bits_reg > HIST_LIM_CFG) begin
            n_eff = HIST_LIM_CFG;
        end else begin
            n_eff = hist_bits_reg;
        end
    end

    assign hmask_wide = ((HIST_MAX + 1)'(1) << n_eff) - (HIST_MAX + 1)'(1);
    assign hmask      = hmask_wide[HIST_MAX-1:0];
    assign hist_used  = hist_reg & hmask;
    assign hist_ext   = HM_W'(hist_used);

    assign addr    = s_tdata[ADDR_W-1:0];
    assign word_lo = addr[INDEX_BITS+1:2];

    assign push_entry.idx   = word_lo ^ hist_ext[INDEX_BITS-1:0];
    assign push_entry.taken = s_tdata[ADDR_W];

    // Shift right, outcome enters at the top of the effective length.
    assign taken_bit = s_tdata[ADDR_W] ? (HIST_MAX'(1) << (n_eff - CFG_W'(1))) : '0;
    assign hist_next = ((hist_used >> 1) | taken_bit) & hmask;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_bits_reg <= HIST_BITS_RESET;
            hist_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                hist_bits_reg <= cfg_data;
            end
            if (push) begin
                hist_reg <= hist_next;
            end
        end
    end

endmodule

// ===== rtl/core/gbp_queue.sv =====
// Short FIFO between the front end and the table update stage.
`timescale 1ns / 1ps
module gbp_queue import gbp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  q_entry_t  push_entry,
    input  logic      pop,
    output q_entry_t  head,
    output q_status_t status
);

    q_entry_t           entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign head              = entries[rd_ptr_reg];
    assign status.count      = count_reg;
    assign status.head_valid = (count_reg != '0);
    assign status.full       = (count_reg == Q_CNT_W'(Q_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/gbp_back.sv =====
// Back end: counter table read-modify-write with forwarding, totals and output register.
`timescale 1ns / 1ps
module gbp_back import gbp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_entry_t             head,
    input  q_status_t            q_status,
    output logic                 pop,
    output back_status_t         status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic [CTR_W-1:0]      table_mem [2**INDEX_BITS];
    logic [CTR_W-1:0]      rd_data_reg;
    logic                  fwd_hit_reg;
    logic [CTR_W-1:0]      fwd_val_reg;

    logic                  b_valid_reg;
    logic [INDEX_BITS-1:0] b_idx_reg;
    logic                  b_taken_reg;

    logic [INDEX_BITS-1:0] clr_idx_reg;
    logic                  clr_done_reg;

    logic [TOTAL_W-1:0]    bc_reg;
    logic [TOTAL_W-1:0]    mc_reg;
    logic [TOTAL_W-1:0]    bc_next;
    logic [TOTAL_W-1:0]    mc_next;

    logic                  m_valid_reg;
    logic [M_TDATA_W-1:0]  m_data_reg;

    logic                  b_adv;
    logic [CTR_W-1:0]      ctr_cur;
    logic [CTR_W-1:0]      ctr_new;
    logic                  pred;
    logic                  miss;
    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_wa;
    logic [CTR_W-1:0]      mem_wd;

    assign b_adv = b_valid_reg && (!m_valid_reg || m_tready);
    assign pop   = q_status.head_valid && clr_done_reg && (!b_valid_reg || b_adv);

    assign status.clr_done = clr_done_reg;
    assign status.busy     = b_valid_reg || m_valid_reg;

    // Take the value just written by the previous word when it hit the same entry.
    assign ctr_cur = fwd_hit_reg ? fwd_val_reg : rd_data_reg;
    assign pred    = (ctr_cur >= CTR_INIT);
    assign miss    = (pred != b_taken_reg);

    always_comb begin
        ctr_new = ctr_cur;
        if (b_taken_reg && ctr_cur != CTR_MAX) begin
            ctr_new = ctr_cur + CTR_W'(1);
        end else if (!b_taken_reg && ctr_cur != CTR_MIN) begin
            ctr_new = ctr_cur - CTR_W'(1);
        end
    end

    assign bc_next = (bc_reg == '1) ? bc_reg : bc_reg + TOTAL_W'(1);
    assign mc_next = (miss && mc_reg != '1) ? mc_reg + TOTAL_W'(1) : mc_reg;

    assign mem_we = !clr_done_reg || b_adv;
    assign mem_wa = clr_done_reg ? b_idx_reg : clr_idx_reg;
    assign mem_wd = clr_done_reg ? ctr_new : CTR_INIT;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_wa] <= mem_wd;
        end
        if (pop) begin
            rd_data_reg <= table_mem[head.idx];
            fwd_hit_reg <= b_adv && (b_idx_reg == head.idx);
            fwd_val_reg <= ctr_new;
            b_idx_reg   <= head.idx;
            b_taken_reg <= head.taken;
        end
        if (b_adv) begin
            m_data_reg <= {{(M_TDATA_W - 2 - 2 * TOTAL_W){1'b0}}, mc_next, bc_next, miss, pred};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clr_done_reg <= 1'b0;
            b_valid_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            bc_reg       <= '0;
            mc_reg       <= '0;
        end else begin
            if (!clr_done_reg) begin
                clr_idx_reg <= clr_idx_reg + INDEX_BITS'(1);
                if (clr_idx_reg == '1) begin
                    clr_done_reg <= 1'b1;
                end
            end
            if (pop) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            if (b_adv) begin
                m_valid_reg <= 1'b1;
                bc_reg      <= bc_next;
                mc_reg      <= mc_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
